// ===== design/ddmr_pkg.sv =====
// Shared types, constants and font table for the decimal dot-matrix renderer.
package ddmr_pkg;

    // Number geometry and font geometry.
    localparam int MAX_DIGITS = 9;
    localparam int GLYPH_W    = 3;
    localparam int ROWS       = 5;
    localparam int ROW_W      = 51;
    localparam int WIDTH_W    = 6;
    localparam int ROW_IDX_W  = 3;
    localparam int GAP_W      = 2;
    localparam int PITCH_W    = 3;
    localparam int CNT_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Reset value of the gap register.
    localparam logic [GAP_W-1:0] GAP_RESET = 2'd2;

    // Register map: byte address bit 2 selects the register index.
    localparam int                PADDR_W  = 3;
    localparam logic [0:0]        REG_GAP  = 1'b0;

    // Accepted values fit in 30 bits, since the limit is at most 10^9.
    localparam int VALUE_W = 30;
    localparam int RECIP_W = 32;
    localparam int PROD_W  = VALUE_W + RECIP_W;
    localparam int Q_SHIFT = 35;
    localparam int Q_W     = PROD_W - Q_SHIFT;

    // Reciprocal of ten: floor(v * RECIP / 2^35) equals v / 10 for any 32-bit v.
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    // Ten to the power n, evaluated at elaboration.
    function automatic longint pow10(input int n);
        longint acc;
        acc = 1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    localparam logic [31:0] VALUE_LIMIT = 32'(pow10(MAX_DIGITS));

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [ROW_IDX_W-1:0] row_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic done;
    } status_t;

    // Font row lookup. Bit 0 of a row is the left column of the glyph.
    function automatic logic [GLYPH_W-1:0] font_row(input logic [3:0] digit,
                                                    input logic [ROW_IDX_W-1:0] row);
        logic [GLYPH_W*ROWS-1:0] glyph;
        case (digit)
            4'd0:    glyph = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    glyph = {3'd7, 3'd2, 3'd2, 3'd3, 3'd2};
            4'd2:    glyph = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd3:    glyph = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
            4'd4:    glyph = {3'd4, 3'd4, 3'd7, 3'd5, 3'd5};
            4'd5:    glyph = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6:    glyph = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            4'd7:    glyph = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
            4'd8:    glyph = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    glyph = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            default: glyph = '0;
        endcase
        return glyph[row*GLYPH_W +: GLYPH_W];
    endfunction

endpackage

// ===== design/ddmr_ctrl.sv =====
// Controller state machine: input acceptance, digit sequencing and row output.
module ddmr_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ddmr_pkg::ROW_IDX_W-1:0] m_row_index,
    output logic                           m_error,
    output logic                           m_last,
    input  ddmr_pkg::status_t              status,
    output ddmr_pkg::cmd_t                 cmd
);

    ddmr_pkg::state_t                 state_reg, state_next;
    logic [ddmr_pkg::ROW_IDX_W-1:0]   row_reg, row_next;
    logic                             last_row;

    // State and row counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddmr_pkg::ST_IDLE;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    assign last_row = (row_reg == ddmr_pkg::ROW_IDX_W'(ddmr_pkg::ROWS - 1));

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.row_sel  = row_reg;
        case (state_reg)
            ddmr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    row_next   = '0;
                    state_next = ddmr_pkg::ST_DIGIT;
                end
            end
            ddmr_pkg::ST_DIGIT: begin
                cmd.step = !status.err;
                if (status.err || status.done) begin
                    state_next = ddmr_pkg::ST_EMIT;
                end
            end
            ddmr_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.err || last_row) begin
                        state_next = ddmr_pkg::ST_IDLE;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ddmr_pkg::ST_IDLE;
            end
        endcase
    end

    // Result sideband fields.
    assign m_row_index = row_reg;
    assign m_error     = status.err;
    assign m_last      = status.err || last_row;

    // The block works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input accepted while results are pending");

    // Error results are always single.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_last && (m_row_index == '0)))
        else $error("error result not marked last");

    // Rows advance by one after each non-final transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
        (m_valid && (m_row_index == $past(m_row_index) + 1'b1)))
        else $error("row sequence broken");

endmodule

// ===== design/ddmr_datapath.sv =====
// Datapath: range check, digit extraction by reciprocal multiply, row bitmap build.
module ddmr_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ddmr_pkg::cmd_t                    cmd,
    output ddmr_pkg::status_t                 status,
    input  logic signed [31:0]                s_value,
    input  logic [ddmr_pkg::GAP_W-1:0]        gap_columns,
    output logic [ddmr_pkg::ROW_W-1:0]        m_row_bits,
    output logic [ddmr_pkg::WIDTH_W-1:0]      m_width
);

    logic [ddmr_pkg::VALUE_W-1:0] v_reg;
    logic [ddmr_pkg::PROD_W-1:0]  prod_reg;
    logic                         err_reg;
    logic [ddmr_pkg::CNT_W-1:0]   cnt_reg;
    logic [ddmr_pkg::WIDTH_W-1:0] width_reg;
    logic [ddmr_pkg::ROW_W-1:0]   rows_reg [ddmr_pkg::ROWS];

    logic [ddmr_pkg::Q_W-1:0]               q;
    logic [ddmr_pkg::VALUE_W-1:0]           q_times_ten;
    logic [ddmr_pkg::VALUE_W-1:0]           rem_full;
    logic [3:0]                             digit;
    logic [ddmr_pkg::Q_W+ddmr_pkg::RECIP_W-1:0] q_prod;
    logic [ddmr_pkg::PITCH_W-1:0]           pitch;
    logic                                   first_digit;
    logic                                   in_range;

    // Quotient and remainder of the current value by ten.
    assign q           = prod_reg[ddmr_pkg::PROD_W-1:ddmr_pkg::Q_SHIFT];
    assign q_times_ten = ddmr_pkg::VALUE_W'({q, 3'b000}) + ddmr_pkg::VALUE_W'({q, 1'b0});
    assign rem_full    = v_reg - q_times_ten;
    assign digit       = rem_full[3:0];
    assign q_prod      = q * ddmr_pkg::RECIP_TEN;

    assign pitch       = ddmr_pkg::PITCH_W'(ddmr_pkg::GLYPH_W) + {1'b0, gap_columns};
    assign first_digit = (cnt_reg == '0);
    assign in_range    = !s_value[31] && (unsigned'(s_value) < ddmr_pkg::VALUE_LIMIT);

    // Digit counter, kept under reset since it steers the step sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Value, product, width and error registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg    <= s_value[ddmr_pkg::VALUE_W-1:0];
            prod_reg <= s_value[ddmr_pkg::VALUE_W-1:0] * ddmr_pkg::RECIP_TEN;
            err_reg  <= !in_range;
        end else if (cmd.step) begin
            v_reg     <= ddmr_pkg::VALUE_W'(q);
            prod_reg  <= ddmr_pkg::PROD_W'(q_prod);
            width_reg <= first_digit ? ddmr_pkg::WIDTH_W'(ddmr_pkg::GLYPH_W)
                                     : width_reg + ddmr_pkg::WIDTH_W'(pitch);
        end
    end

    // Each new, more significant digit enters at the left, older columns move right.
    always_ff @(posedge aclk) begin
        for (int r = 0; r < ddmr_pkg::ROWS; r++) begin
            if (cmd.step) begin
                if (first_digit) begin
                    rows_reg[r] <= ddmr_pkg::ROW_W'(
                        ddmr_pkg::font_row(digit, ddmr_pkg::ROW_IDX_W'(r)));
                end else begin
                    rows_reg[r] <= (rows_reg[r] << pitch) | ddmr_pkg::ROW_W'(
                        ddmr_pkg::font_row(digit, ddmr_pkg::ROW_IDX_W'(r)));
                end
            end
        end
    end

    // Status to the controller.
    assign status.err  = err_reg;
    assign status.done = (q == '0) ||
                         (cnt_reg == ddmr_pkg::CNT_W'(ddmr_pkg::MAX_DIGITS - 1));

    // Result payload; error results carry no bitmap.
    assign m_row_bits = err_reg ? '0 : rows_reg[cmd.row_sel];
    assign m_width    = err_reg ? '0 : width_reg;

endmodule

// ===== design/decimal_dot_matrix_renderer_core.sv =====
// Top level: configuration register port, controller and datapath.
// Each item is accepted in idle, its digits are extracted, then its rows are emitted.
// Digit extraction yields one digit per cycle through the reciprocal multiplier.
// A new item is taken only after the last row of the previous one; five row transfers per in-range item.
// An out-of-range value gives one error result.
// Reset (synchronous, active low) returns to idle and sets gap_columns to 2.
module decimal_dot_matrix_renderer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ddmr_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ddmr_pkg::ROW_W-1:0]       m_row_bits,
    output logic [ddmr_pkg::ROW_IDX_W-1:0]   m_row_index,
    output logic [ddmr_pkg::WIDTH_W-1:0]     m_width,
    output logic                             m_error,
    output logic                             m_last
);

    logic [ddmr_pkg::GAP_W-1:0] gap_columns_reg;
    ddmr_pkg::cmd_t             cmd;
    ddmr_pkg::status_t          status;
    logic                       reg_write;

    // Register write on the access phase of an APB write transfer.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == ddmr_pkg::REG_GAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_columns_reg <= ddmr_pkg::GAP_RESET;
        end else if (reg_write) begin
            gap_columns_reg <= pwdata[ddmr_pkg::GAP_W-1:0];
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == ddmr_pkg::REG_GAP) ? 32'(gap_columns_reg) : '0;

    ddmr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_error     (m_error),
        .m_last      (m_last),
        .status      (status),
        .cmd         (cmd)
    );

    ddmr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_value     (s_value),
        .gap_columns (gap_columns_reg),
        .m_row_bits  (m_row_bits),
        .m_width     (m_width)
    );

endmodule

// ===== sim/decimal_dot_matrix_renderer_core_tb.sv =====
// Self-checking testbench for the decimal dot-matrix renderer core.
`timescale 1ns / 1ps

module decimal_dot_matrix_renderer_core_tb;

    localparam int          CLK_HALF    = 5;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 30;
    localparam int unsigned DRAW_LIMIT  = 1000000000;

    // Byte addresses of the register file; the spare index has no register behind it.
    localparam logic [ddmr_pkg::PADDR_W-1:0] ADDR_GAP   = {ddmr_pkg::REG_GAP, 2'b00};
    localparam logic [ddmr_pkg::PADDR_W-1:0] ADDR_SPARE = {~ddmr_pkg::REG_GAP, 2'b00};

    // One row transfer as seen on the result channel.
    typedef struct packed {
        logic [ddmr_pkg::ROW_W-1:0]     row_bits;
        logic [ddmr_pkg::ROW_IDX_W-1:0] row_index;
        logic [ddmr_pkg::WIDTH_W-1:0]   width;
        logic                           error;
        logic                           last;
    } row_result_t;

    // Glyph rows, top row first. Bit 0 is the left column of the glyph.
    localparam logic [ddmr_pkg::GLYPH_W-1:0] GLYPH [10][ddmr_pkg::ROWS] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
        '{3'd2, 3'd3, 3'd2, 3'd2, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd4, 3'd4},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd4, 3'd4, 3'd4, 3'd4},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd4, 3'd7}
    };

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [ddmr_pkg::PADDR_W-1:0]   paddr       = '0;
    logic [31:0]                    pwdata      = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic signed [31:0]             s_value     = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [ddmr_pkg::ROW_W-1:0]     m_row_bits;
    logic [ddmr_pkg::ROW_IDX_W-1:0] m_row_index;
    logic [ddmr_pkg::WIDTH_W-1:0]   m_width;
    logic                           m_error;
    logic                           m_last;

    // Testbench copy of the gap register and queues of numbers and rows.
    logic [ddmr_pkg::GAP_W-1:0]     gap_setting = ddmr_pkg::GAP_RESET;
    logic signed [31:0]             pending_values[$];
    row_result_t                    expected_rows[$];
    int                             mismatch_count = 0;
    int                             cycle_count    = 0;
    bit                             idling_on      = 1'b1;
    bit                             hold_req       = 1'b0;
    bit                             hold_done      = 1'b0;
    int                             hold_cnt       = 0;
    int                             sink_stall     = 0;
    int                             src_gap        = 0;

    decimal_dot_matrix_renderer_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_bits  (m_row_bits),
        .m_row_index (m_row_index),
        .m_width     (m_width),
        .m_error     (m_error),
        .m_last      (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // Ten to the power n.
    function automatic int unsigned decade(input int n);
        int unsigned acc;
        acc = 1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    // Draw one number and queue the rows it should produce.
    function automatic void render_rows(input logic signed [31:0] value);
        row_result_t                  row;
        logic [3:0]                   digits [ddmr_pkg::MAX_DIGITS];
        int unsigned                  rest;
        int                           n;
        int                           pitch;
        logic [ddmr_pkg::ROW_W-1:0]   bits;
        logic [ddmr_pkg::WIDTH_W-1:0] span;
        row = '0;
        n = 0;
        if (value < 0 || $unsigned(value) >= DRAW_LIMIT) begin
            // Out of range: one error row with everything else zero.
            row.error = 1'b1;
            row.last  = 1'b1;
            expected_rows.push_back(row);
            return;
        end
        rest = $unsigned(value);
        do begin
            digits[n] = 4'(rest % 10);
            n++;
            rest = rest / 10;
        end while (rest != 0 && n < ddmr_pkg::MAX_DIGITS);
        pitch = ddmr_pkg::GLYPH_W + int'(gap_setting);
        span  = ddmr_pkg::WIDTH_W'(ddmr_pkg::GLYPH_W * n + int'(gap_setting) * (n - 1));
        // Most significant digit sits at the left edge.
        for (int r = 0; r < ddmr_pkg::ROWS; r++) begin
            bits = '0;
            for (int k = 0; k < n; k++) begin
                bits = bits | (ddmr_pkg::ROW_W'(GLYPH[digits[n - 1 - k]][r]) << (pitch * k));
            end
            row.row_bits  = bits;
            row.row_index = ddmr_pkg::ROW_IDX_W'(r);
            row.width     = span;
            row.error     = 1'b0;
            row.last      = (r == ddmr_pkg::ROWS - 1);
            expected_rows.push_back(row);
        end
    endfunction

    // Random number, mostly drawable with an even spread of digit counts.
    function automatic logic signed [31:0] pick_value();
        int unsigned kind;
        int          n;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            n = $urandom_range(1, ddmr_pkg::MAX_DIGITS);
            return $urandom_range(decade(n) - 1, (n == 1) ? 0 : decade(n - 1));
        end else if (kind < 80) begin
            return $urandom();
        end else if (kind < 88) begin
            return -$signed($urandom_range(1, 1000));
        end else if (kind < 95) begin
            return $urandom_range(DRAW_LIMIT + 10, DRAW_LIMIT - 10);
        end
        return $urandom_range(32'h7FFF_FFFF, DRAW_LIMIT);
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [ddmr_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_GAP) begin
            gap_setting = data[ddmr_pkg::GAP_W-1:0];
        end
    endtask

    // Register read of the gap setting, checked against the local copy.
    task automatic check_gap_reg();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_GAP;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== 32'(gap_setting)) begin
            $error("gap_columns: expected %0d, got %0d", gap_setting, prdata);
            mismatch_count++;
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every number is taken and every row has come back.
    task automatic drain();
        while (pending_values.size() != 0 || s_valid || expected_rows.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            pending_values.push_back(pick_value());
        end
    endtask

    // Input driver: presents queued numbers and predicts each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                render_rows(s_value);
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_values.size() != 0) begin
                    s_valid <= 1'b1;
                    s_value <= pending_values.pop_front();
                    if (idling_on && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(1, 11);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each row transfer and paces m_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row transfer: row_index %0d error %0b",
                           m_row_index, m_error);
                    mismatch_count++;
                end else begin
                    row_result_t want;
                    want = expected_rows.pop_front();
                    if (m_row_bits !== want.row_bits) begin
                        $error("row_bits: expected %h, got %h", want.row_bits, m_row_bits);
                        mismatch_count++;
                    end
                    if (m_row_index !== want.row_index) begin
                        $error("row_index: expected %0d, got %0d",
                               want.row_index, m_row_index);
                        mismatch_count++;
                    end
                    if (m_width !== want.width) begin
                        $error("width: expected %0d, got %0d", want.width, m_width);
                        mismatch_count++;
                    end
                    if (m_error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, m_error);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            // Long hold-off first, then short random stalls.
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_cnt  <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else if (sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                m_ready    <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                sink_stall <= $urandom_range(0, 10);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("decimal_dot_matrix_renderer_core_tb: FAIL");
            $finish;
        end
    end

    // Test sequence: directed numbers, then random phases at several gap settings.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        check_gap_reg();

        // Zero, single digits, every glyph, the range edges and error values.
        pending_values = '{0, 5, 9, 10, 42, 100, 868686, 7070707, 123456789,
                           987654320, 100000000, 999999999, 1000000000, 1000000001,
                           32'sh7FFF_FFFF, -1, -999, 32'sh8000_0000, 1, 8};
        drain();
        queue_random(80);
        drain();

        // A write past the register list must leave the gap untouched.
        write_reg(ADDR_SPARE, 32'h0000_0001);
        check_gap_reg();
        write_reg(ADDR_GAP, 32'hFFFF_FFFC);
        check_gap_reg();
        queue_random(100);
        hold_req = 1'b1;
        drain();

        write_reg(ADDR_GAP, 32'd3);
        check_gap_reg();
        pending_values.push_back(999999999);
        pending_values.push_back(888888888);
        queue_random(100);
        drain();

        write_reg(ADDR_GAP, 32'd1);
        check_gap_reg();
        queue_random(80);
        drain();

        // Closing phase at full rate on both sides.
        write_reg(ADDR_GAP, 32'd2);
        check_gap_reg();
        idling_on = 1'b0;
        queue_random(60);
        drain();

        if (mismatch_count == 0) begin
            $display("decimal_dot_matrix_renderer_core_tb: PASS");
        end else begin
            $display("decimal_dot_matrix_renderer_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ddmr_pkg.sv
design/ddmr_ctrl.sv
design/ddmr_datapath.sv
design/decimal_dot_matrix_renderer_core.sv
sim/decimal_dot_matrix_renderer_core_tb.sv
